FILE: sv/assert_macros.svh
// Assertion macros shared by the flicker evidence RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every aclk edge outside reset
`define FPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle
`define FPE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/fpe_pkg.sv
// Package of the flicker evidence block: types, constants and table functions
package fpe_pkg;

    // Default geometry and table size
    localparam int DEF_SENSOR_WIDTH    = 1280;
    localparam int DEF_SENSOR_HEIGHT   = 720;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    // Configuration register indexes
    localparam logic [2:0] REG_WIN_START = 3'd0;
    localparam logic [2:0] REG_WIN_END   = 3'd1;
    localparam logic [2:0] REG_TFREQ     = 3'd2;
    localparam logic [2:0] REG_SIGMA     = 3'd3;
    localparam logic [2:0] REG_TOL       = 3'd4;

    // Per-pixel word: valid, polarity, last transition (33 signed), evidence (32)
    localparam int WORD_W = 67;
    localparam logic signed [32:0] TRANS_RESET = -33'sd1000000;
    localparam logic [WORD_W-1:0] WORD_RESET = {2'b00, TRANS_RESET, 32'd0};

    // Fixed-point constants
    localparam logic [63:0] FREQ_NUM_Q8      = 64'd256000000;
    localparam logic [30:0] INV_SQRT_2PI_Q32 = 31'd1713444047;

    // Divider operation widths
    localparam logic [4:0] DIV_FREQ_BITS = 5'd28;
    localparam logic [4:0] DIV_Z_BITS    = 5'd21;
    localparam logic [4:0] DIV_W_BITS    = 5'd23;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_DEV,
        ST_SQ,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_IDX,
        ST_EXP,
        ST_MUL,
        ST_DIV3_GO,
        ST_DIV3_WAIT,
        ST_WRITE,
        ST_DONE
    } fpe_state_t;

    typedef struct packed {
        logic       start;
        logic [4:0] nbits;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Ratio exp(-x) in Q30 from a 16-term Taylor sum, x in Q30
    function automatic logic [63:0] exp_ratio(input logic [63:0] x);
        logic [63:0] term;
        longint      sum;
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        term = ((term * x) >> 30) / 1;  sum = sum - longint'(term);
        term = ((term * x) >> 30) / 2;  sum = sum + longint'(term);
        term = ((term * x) >> 30) / 3;  sum = sum - longint'(term);
        term = ((term * x) >> 30) / 4;  sum = sum + longint'(term);
        term = ((term * x) >> 30) / 5;  sum = sum - longint'(term);
        term = ((term * x) >> 30) / 6;  sum = sum + longint'(term);
        term = ((term * x) >> 30) / 7;  sum = sum - longint'(term);
        term = ((term * x) >> 30) / 8;  sum = sum + longint'(term);
        term = ((term * x) >> 30) / 9;  sum = sum - longint'(term);
        term = ((term * x) >> 30) / 10; sum = sum + longint'(term);
        term = ((term * x) >> 30) / 11; sum = sum - longint'(term);
        term = ((term * x) >> 30) / 12; sum = sum + longint'(term);
        term = ((term * x) >> 30) / 13; sum = sum - longint'(term);
        term = ((term * x) >> 30) / 14; sum = sum + longint'(term);
        term = ((term * x) >> 30) / 15; sum = sum - longint'(term);
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    // Table entry i: ratio^i in Q30, scaled to Q24 and capped
    function automatic logic [23:0] exp_entry(input logic [63:0] r, input int i);
        logic [63:0] e;
        logic [63:0] v;
        e = 64'd1 << 30;
        for (int j = 0; j < i; j++) begin
            e = (e * r) >> 30;
        end
        v = e >> 6;
        return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

endpackage

FILE: sv/event_pixel_flicker_evidence.sv
// Per-pixel flicker evidence for an event camera: pixel store, sequencer and datapath.
// After reset the block sweeps the pixel store once, one pixel per cycle
// (SENSOR_WIDTH*SENSOR_HEIGHT pixels, 921600 at the default size), and takes no
// event meanwhile; configuration writes are taken at any time. Events are then handled
// one at a time: a pixel outside the sensor goes straight to the write and done states,
// an event that adds no weight reads and evaluates the stored word first, and a
// polarity change inside the window also runs three passes through the shared
// divider (28, 21 and 23 quotient bits), ending after the second pass when it already
// lands in the Gaussian tail. The result is presented in the same cycle that s_ready
// rises for the next request. A waiting result does not hold off the next
// event's work until that event's own result is ready.
`include "assert_macros.svh"

module event_pixel_flicker_evidence #(
    parameter int SENSOR_WIDTH    = fpe_pkg::DEF_SENSOR_WIDTH,
    parameter int SENSOR_HEIGHT   = fpe_pkg::DEF_SENSOR_HEIGHT,
    parameter int EXP_TABLE_DEPTH = fpe_pkg::DEF_EXP_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Event input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_pixel_x,
    input  logic [9:0]  s_pixel_y,
    input  logic [31:0] s_timestamp_us,
    input  logic        s_polarity,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_evidence,
    output logic [31:0] m_max_evidence,
    output logic        m_above_tolerance,
    output logic [22:0] m_weight_added,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpe_pkg::*;

    localparam int NPIX   = SENSOR_WIDTH * SENSOR_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);
    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int DEP_W  = IDX_W + 1;
    localparam logic [DEP_W-1:0] DEPTH_C    = DEP_W'(EXP_TABLE_DEPTH);
    localparam logic [63:0]      EXP_STEP   = (64'd16 << 30) / EXP_TABLE_DEPTH;
    localparam logic [63:0]      EXP_RATIO  = exp_ratio(EXP_STEP);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NPIX - 1);

    // Configuration registers
    logic [31:0] win_start_reg;
    logic [31:0] win_end_reg;
    logic [16:0] tfreq_reg;
    logic [15:0] sigma_reg;
    logic [7:0]  tol_reg;
    logic        cfg_wr;

    // Control state
    fpe_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic              start_seen_reg;
    logic [31:0]       origin_ts_reg;
    logic [31:0]       max_reg;
    logic              m_valid_reg;

    // Event payload and datapath registers
    logic [ADDR_W-1:0]  addr_reg;
    logic               oob_reg;
    logic               pol_reg;
    logic signed [32:0] t_reg;
    logic [WORD_W-1:0]  word_reg;
    logic signed [32:0] new_trans_reg;
    logic [33:0]        adt_reg;
    logic               neg_reg;
    logic [28:0]        adev_reg;
    logic [32:0]        d2_reg;
    logic [57:0]        sq_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [23:0]        exp_reg;
    logic [22:0]        wpre_reg;
    logic [22:0]        weight_reg;
    logic [31:0]        ev_new_reg;
    logic [31:0]        out_ev_reg;
    logic [31:0]        out_max_reg;
    logic               out_above_reg;
    logic [22:0]        out_w_reg;

    // Divider interface
    div_cmd_t    div_cmd;
    div_stat_t   div_stat;
    logic [63:0] div_num;
    logic [63:0] div_dsh;
    logic [27:0] div_quot;

    // Store interface
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // Exponential table
    logic [23:0] exp_rom [EXP_TABLE_DEPTH];

    // Combinational datapath
    logic               accept;
    logic               out_free;
    logic [15:0]        s_eff;
    logic signed [32:0] t_in;
    logic               oob_in;
    logic               w_valid;
    logic               w_pol;
    logic signed [32:0] w_trans;
    logic               change;
    logic signed [33:0] dt;
    logic               in_win;
    logic signed [29:0] f8s;
    logic signed [29:0] dev;
    logic [33:0]        idx_prod;
    logic [54:0]        w_prod;
    logic [32:0]        ev_sum;
    logic [31:0]        max_new;
    logic [39:0]        tol_prod;

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
        assign exp_rom[g] = exp_entry(EXP_RATIO, g);
    end

    fpe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NPIX)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    fpe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .num     (div_num),
        .dsh     (div_dsh),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= 32'd950000;
            win_end_reg   <= 32'd1000000;
            tfreq_reg     <= 17'd100;
            sigma_reg     <= 16'd30;
            tol_reg       <= 8'd51;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_WIN_START: win_start_reg <= pwdata;
                REG_WIN_END:   win_end_reg   <= pwdata;
                REG_TFREQ:     tfreq_reg     <= pwdata[16:0];
                REG_SIGMA:     sigma_reg     <= pwdata[15:0];
                REG_TOL:       tol_reg       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_WIN_START: prdata = win_start_reg;
            REG_WIN_END:   prdata = win_end_reg;
            REG_TFREQ:     prdata = {15'd0, tfreq_reg};
            REG_SIGMA:     prdata = {16'd0, sigma_reg};
            REG_TOL:       prdata = {24'd0, tol_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Handshake
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Event time relative to the first event
    assign t_in   = start_seen_reg ? $signed({1'b0, s_timestamp_us} - {1'b0, origin_ts_reg})
                                   : 33'sd0;
    assign oob_in = (32'(s_pixel_x) >= 32'(SENSOR_WIDTH))
                 || (32'(s_pixel_y) >= 32'(SENSOR_HEIGHT));
    assign s_eff  = (sigma_reg == 16'd0) ? 16'd1 : sigma_reg;

    // Stored pixel word
    assign w_valid = ram_rdata[66];
    assign w_pol   = ram_rdata[65];
    assign w_trans = $signed(ram_rdata[64:32]);
    assign change  = w_valid && (w_pol != pol_reg);
    assign dt      = {t_reg[32], t_reg} - {w_trans[32], w_trans};
    assign in_win  = ($signed({1'b0, win_start_reg}) < t_reg)
                  && (t_reg < $signed({1'b0, win_end_reg}));

    // Frequency deviation, table index, weight scale
    assign f8s      = neg_reg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    assign dev      = f8s - $signed({5'd0, tfreq_reg, 8'd0});
    assign idx_prod = div_quot[19:0] * DEPTH_C;
    assign w_prod   = exp_reg * INV_SQRT_2PI_Q32;

    // Evidence update and tolerance test
    assign ev_sum   = {1'b0, word_reg[31:0]} + {10'd0, weight_reg};
    assign max_new  = (ev_new_reg > max_reg) ? ev_new_reg : max_reg;
    assign tol_prod = tol_reg * max_new;

    // Divider operands per pass
    always_comb begin
        div_cmd.start = 1'b0;
        div_cmd.nbits = DIV_FREQ_BITS;
        div_num       = FREQ_NUM_Q8;
        div_dsh       = {3'd0, adt_reg, 27'd0};
        unique case (state_reg)
            ST_DIV1_GO: begin
                div_cmd.start = 1'b1;
            end
            ST_DIV2_GO: begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = DIV_Z_BITS;
                div_num       = {6'd0, sq_reg};
                div_dsh       = {11'd0, d2_reg, 20'd0};
            end
            ST_DIV3_GO: begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = DIV_W_BITS;
                div_num       = {41'd0, wpre_reg};
                div_dsh       = {26'd0, s_eff, 22'd0};
            end
            default: ;
        endcase
    end

    // Store write: clearing sweep or pixel update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {1'b1, pol_reg, new_trans_reg, ev_new_reg};
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = WORD_RESET;
        end else if (state_reg == ST_DONE && !oob_reg && !m_valid_reg) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_DONE && !oob_reg && m_ready) begin
            ram_we = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:      if (accept) state_next = oob_in ? ST_WRITE : ST_READ;
            ST_READ:      state_next = ST_EVAL;
            ST_EVAL:      state_next = (change && in_win && dt != 34'sd0) ? ST_DIV1_GO
                                                                          : ST_WRITE;
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_stat.done) state_next = ST_DEV;
            ST_DEV:       state_next = ST_SQ;
            ST_SQ:        state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (div_stat.done) state_next = div_quot[20] ? ST_WRITE : ST_IDX;
            ST_IDX:       state_next = ST_EXP;
            ST_EXP:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV3_GO;
            ST_DIV3_GO:   state_next = ST_DIV3_WAIT;
            ST_DIV3_WAIT: if (div_stat.done) state_next = ST_WRITE;
            ST_WRITE:     state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers: sweep counter, start time, maximum, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            start_seen_reg <= 1'b0;
            origin_ts_reg  <= 32'd0;
            max_reg        <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (accept && !start_seen_reg) begin
                start_seen_reg <= 1'b1;
                origin_ts_reg  <= s_timestamp_us;
            end
            if (state_reg == ST_DONE && out_free) begin
                max_reg     <= max_new;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                addr_reg   <= ADDR_W'(s_pixel_y * SENSOR_WIDTH) + ADDR_W'(s_pixel_x);
                oob_reg    <= oob_in;
                pol_reg    <= s_polarity;
                t_reg      <= t_in;
                weight_reg <= 23'd0;
                word_reg   <= '0;
            end
            ST_EVAL: begin
                word_reg      <= ram_rdata;
                new_trans_reg <= change ? t_reg : w_trans;
                adt_reg       <= dt[33] ? 34'(-dt) : 34'(dt);
                neg_reg       <= dt[33];
            end
            ST_DEV: begin
                adev_reg <= dev[29] ? 29'(-dev) : 29'(dev);
                d2_reg   <= {32'(s_eff) * 32'(s_eff), 1'b0};
            end
            ST_SQ:  sq_reg  <= adev_reg * adev_reg;
            ST_IDX: idx_reg <= idx_prod[20 +: IDX_W];
            ST_EXP: exp_reg <= exp_rom[idx_reg];
            ST_MUL: wpre_reg <= w_prod[54:32];
            ST_DIV3_WAIT: if (div_stat.done) weight_reg <= div_quot[22:0];
            ST_WRITE: ev_new_reg <= oob_reg ? 32'd0
                                    : (ev_sum[32] ? 32'hFFFF_FFFF : ev_sum[31:0]);
            ST_DONE: if (out_free) begin
                out_ev_reg    <= ev_new_reg;
                out_max_reg   <= max_new;
                out_above_reg <= {ev_new_reg, 8'd0} > tol_prod;
                out_w_reg     <= weight_reg;
            end
            default: ;
        endcase
    end

    assign m_pixel_evidence  = out_ev_reg;
    assign m_max_evidence    = out_max_reg;
    assign m_above_tolerance = out_above_reg;
    assign m_weight_added    = out_w_reg;

    // Assertions
    `FPE_ASSERT(a_no_result_in_clear, (state_reg == ST_CLEAR) |-> !m_valid_reg, "result during clear")
    `FPE_ASSERT(a_div_idle, (state_reg == ST_IDLE) |-> !div_stat.busy, "divider busy while idle")
    `FPE_ASSERT(a_max_bound, m_valid_reg |-> (out_max_reg >= out_ev_reg), "evidence above maximum")
    `FPE_ASSERT(a_weight_ev, (m_valid_reg && out_w_reg != 23'd0) |-> (out_ev_reg != 32'd0), "weight without evidence")
    `FPE_ASSERT_NEXT(a_max_mono, 1'b1, max_reg >= $past(max_reg), "maximum decreased")

endmodule

FILE: sv/fpe_ram.sv
// Generic single-port-write, registered-read RAM
module fpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/fpe_div.sv
// Shared restoring divider, one quotient bit per cycle
module fpe_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpe_pkg::div_cmd_t  cmd,
    input  logic [63:0]        num,
    input  logic [63:0]        dsh,
    output fpe_pkg::div_stat_t stat,
    output logic [27:0]        quot
);
    import fpe_pkg::*;

    logic [63:0] rem_reg,  rem_next;
    logic [63:0] dsh_reg,  dsh_next;
    logic [27:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        ge;

    // Load on start, then trial-subtract the shifted divisor each cycle
    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = rem_reg >= dsh_reg;
        if (cmd.start) begin
            rem_next  = num;
            dsh_next  = dsh;
            quot_next = '0;
            cnt_next  = cmd.nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_reg - dsh_reg : rem_reg;
            quot_next = {quot_reg[26:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

FILE: verif/tb_event_pixel_flicker_evidence.sv
// Testbench for the per-pixel flicker evidence block: directed table, random events, APB phases
`timescale 1ns / 1ps

module tb_event_pixel_flicker_evidence;
    import fpe_pkg::*;

    localparam int  WIDTH     = 1280;
    localparam int  HEIGHT    = 720;
    localparam int  EXP_DEPTH = 256;
    localparam longint LIMIT  = 6000000;
    localparam int  SETTLE    = 120;

    typedef struct {
        bit [31:0] evidence;
        bit [31:0] maximum;
        bit        above;
        bit [22:0] weight;
    } flicker_res_t;

    typedef struct {
        bit [10:0] x;
        bit [9:0]  y;
        bit [31:0] ts;
        bit        pol;
        bit        typed;
        bit [31:0] ev;
        bit [31:0] mx;
        bit        ab;
        bit [22:0] w;
    } event_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [10:0] s_pixel_x;
    logic [9:0]  s_pixel_y;
    logic [31:0] s_timestamp_us;
    logic        s_polarity;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_pixel_evidence;
    logic [31:0] m_max_evidence;
    logic        m_above_tolerance;
    logic [22:0] m_weight_added;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    event_pixel_flicker_evidence uut (.*);

    // Predictor state: configuration, start time, sparse pixel store
    bit [31:0] win_start, win_end;
    bit [16:0] target_hz;
    bit [15:0] sigma;
    bit [7:0]  tol_q8;
    bit [31:0] origin_ts;
    bit        start_taken;
    bit [31:0] max_ev;
    bit [23:0] exp_rom[EXP_DEPTH];
    bit [1:0]  pix_pol[int];
    longint    pix_trans[int];
    bit [31:0] pix_ev[int];

    flicker_res_t expected_q[$];
    longint cycles;
    int     errors;
    int     events_sent;
    int     results_seen;
    int     weighted_seen;
    bit     holdoff_req;
    int     burst_left;

    // Clock, cycle counter and timeout
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Build the exp(-z) table in Q24 from a Q30 Taylor ratio
    function automatic void build_exp_rom();
        bit [63:0] x, term, r, e, v;
        longint    acc;
        x    = (64'd16 << 30) / EXP_DEPTH;
        term = 64'd1 << 30;
        acc  = longint'(64'd1 << 30);
        for (int k = 1; k < 16; k++) begin
            term = ((term * x) >> 30) / k;
            if (k % 2) acc -= longint'(term);
            else       acc += longint'(term);
        end
        r = (acc > 0) ? 64'(acc) : 64'd0;
        e = 64'd1 << 30;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            v = e >> 6;
            exp_rom[i] = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
            e = (e * r) >> 30;
        end
    endfunction

    // Gaussian weight of the blink frequency implied by interval dt
    function automatic bit [31:0] blink_weight(longint dt);
        bit [63:0] adt, s, adev, q, idx, w;
        longint    f8, dev;
        adt = (dt < 0) ? 64'(-dt) : 64'(dt);
        s   = (sigma == 0) ? 64'd1 : 64'(sigma);
        f8  = longint'(64'd256000000 / adt);
        if (dt < 0) f8 = -f8;
        dev  = f8 - longint'(target_hz) * 256;
        adev = (dev < 0) ? 64'(-dev) : 64'(dev);
        q    = (adev * adev) / (2 * s * s);
        if (q >= (64'd16 << 16)) return 0;
        idx = (q * EXP_DEPTH) >> 20;
        if (idx >= EXP_DEPTH) return 0;
        w = (64'(exp_rom[idx]) * 64'd1713444047) >> 32;
        return 32'(w / s);
    endfunction

    // Update the pixel store for one event and return its result
    function automatic flicker_res_t evidence_update(bit [10:0] x, bit [9:0] y,
                                                     bit [31:0] ts, bit pol);
        flicker_res_t res;
        longint    t, dt, last_t;
        bit [1:0]  last_p;
        bit [31:0] ev, wt;
        bit [32:0] sum;
        int        key;
        if (!start_taken) begin
            origin_ts   = ts;
            start_taken = 1'b1;
        end
        t = longint'(ts) - longint'(origin_ts);
        res = '{0, max_ev, 0, 0};
        if (x >= WIDTH || y >= HEIGHT) return res;
        key    = y * WIDTH + x;
        last_p = pix_pol.exists(key) ? pix_pol[key] : 2'b00;
        last_t = pix_trans.exists(key) ? pix_trans[key] : -1000000;
        ev     = pix_ev.exists(key) ? pix_ev[key] : 32'd0;
        wt     = 0;
        if (last_p[1] && last_p[0] != pol) begin
            dt = t - last_t;
            if (longint'(win_start) < t && t < longint'(win_end) && dt != 0) begin
                wt  = blink_weight(dt);
                sum = 33'(ev) + 33'(wt);
                ev  = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            end
            pix_trans[key] = t;
        end
        pix_pol[key] = {1'b1, pol};
        pix_ev[key]  = ev;
        if (ev > max_ev) max_ev = ev;
        res.evidence = ev;
        res.maximum  = max_ev;
        res.above    = (64'(ev) * 256 > 64'(tol_q8) * 64'(max_ev));
        res.weight   = wt[22:0];
        return res;
    endfunction

    // APB write followed by a readback of the same register
    task automatic reg_write(logic [2:0] index, bit [31:0] value);
        bit [31:0] mask;
        case (index)
            REG_TFREQ: mask = 32'h1FFFF;
            REG_SIGMA: mask = 32'hFFFF;
            REG_TOL:   mask = 32'hFF;
            default:   mask = 32'hFFFFFFFF;
        endcase
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {index, 2'b00}; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        @(negedge aclk);
        psel = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== (value & mask)) begin
            $error("readback reg %0d: expected %h actual %h", index, value & mask, prdata);
            errors++;
        end
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        case (index)
            REG_WIN_START: win_start = value;
            REG_WIN_END:   win_end   = value;
            REG_TFREQ:     target_hz = value[16:0];
            REG_SIGMA:     sigma     = value[15:0];
            REG_TOL:       tol_q8    = value[7:0];
            default: ;
        endcase
    endtask

    // Offer one event, hold it until accepted, then record its expected result
    task automatic send_event(bit [10:0] x, bit [9:0] y, bit [31:0] ts, bit pol,
                              bit typed, flicker_res_t typed_res);
        flicker_res_t res;
        @(negedge aclk);
        s_valid = 1'b1; s_pixel_x = x; s_pixel_y = y;
        s_timestamp_us = ts; s_polarity = pol;
        do @(posedge aclk); while (!s_ready);
        res = evidence_update(x, y, ts, pol);
        expected_q.insert(expected_q.size(), typed ? typed_res : res);
        events_sent++;
        // Bursts with random gaps between them
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        flicker_res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_weight_added != 0) weighted_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                if (m_pixel_evidence !== exp_res.evidence) begin
                    $error("pixel_evidence: expected %0d actual %0d",
                           exp_res.evidence, m_pixel_evidence);
                    errors++;
                end
                if (m_max_evidence !== exp_res.maximum) begin
                    $error("max_evidence: expected %0d actual %0d",
                           exp_res.maximum, m_max_evidence);
                    errors++;
                end
                if (m_above_tolerance !== exp_res.above) begin
                    $error("above_tolerance: expected %0d actual %0d",
                           exp_res.above, m_above_tolerance);
                    errors++;
                end
                if (m_weight_added !== exp_res.weight) begin
                    $error("weight_added: expected %0d actual %0d",
                           exp_res.weight, m_weight_added);
                    errors++;
                end
            end
        end
    end

    // Receiver: stall pattern in chunks, plus one long hold-off on request
    initial begin
        int mode;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 48; i++) begin
                @(negedge aclk);
                if (holdoff_req) begin
                    m_ready = 1'b0;
                    repeat (500) @(negedge aclk);
                    holdoff_req = 1'b0;
                end
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = ($urandom_range(0, 3) != 0);
                    2:       m_ready = ($urandom_range(0, 9) < 3);
                    default: m_ready = (i % 8) < 5;
                endcase
            end
        end
    end

    // Directed table; typed rows are obvious from the defaults
    event_row_t table_rows[] = '{
        '{0,    0,    32'd1000,       1, 1, 0, 0, 0, 0},
        '{1280, 0,    32'd5000,       0, 1, 0, 0, 0, 0},
        '{2047, 1023, 32'hFFFFFFFF,   1, 1, 0, 0, 0, 0},
        '{0,    0,    32'd2000,       1, 1, 0, 0, 0, 0},
        '{0,    0,    32'd3000,       0, 1, 0, 0, 0, 0},
        '{1279, 719,  32'd0,          0, 1, 0, 0, 0, 0},
        '{1279, 719,  32'd961000,     1, 0, 0, 0, 0, 0},
        '{1279, 719,  32'd971000,     0, 0, 0, 0, 0, 0},
        '{1279, 719,  32'd981000,     1, 0, 0, 0, 0, 0},
        '{1279, 719,  32'd981000,     0, 0, 0, 0, 0, 0},
        '{1279, 719,  32'd976000,     1, 0, 0, 0, 0, 0},
        '{5,    5,    32'd956000,     1, 0, 0, 0, 0, 0},
        '{5,    5,    32'd966000,     0, 0, 0, 0, 0, 0},
        '{0,    0,    32'd1000999,    1, 0, 0, 0, 0, 0},
        '{0,    0,    32'd1001000,    0, 0, 0, 0, 0, 0},
        '{1,    1,    32'd941000,     0, 0, 0, 0, 0, 0},
        '{1,    1,    32'd951000,     1, 0, 0, 0, 0, 0},
        '{640,  360,  32'h7FFFFFFF,   1, 0, 0, 0, 0, 0},
        '{640,  360,  32'h80000000,   0, 0, 0, 0, 0, 0},
        '{1024, 512,  32'd958000,     0, 0, 0, 0, 0, 0},
        '{1024, 512,  32'd959000,     1, 0, 0, 0, 0, 0}
    };

    // Main sequence
    initial begin
        bit [31:0]  phase_cfg[9][5];
        int         pix_x[12], pix_y[12];
        bit [31:0]  pix_t[12];
        bit         pix_p[12];
        bit [31:0]  half_period, jitter;
        flicker_res_t typed_res;
        int         p;

        cycles = 0; errors = 0; events_sent = 0; results_seen = 0; weighted_seen = 0;
        holdoff_req = 1'b0; burst_left = 8;
        aresetn = 1'b0; s_valid = 1'b0; s_pixel_x = '0; s_pixel_y = '0;
        s_timestamp_us = '0; s_polarity = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        build_exp_rom();
        win_start = 950000; win_end = 1000000; target_hz = 100; sigma = 30; tol_q8 = 51;
        start_taken = 1'b0; origin_ts = 0; max_ev = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset settings
        foreach (table_rows[i]) begin
            typed_res = '{table_rows[i].ev, table_rows[i].mx, table_rows[i].ab,
                          table_rows[i].w};
            send_event(table_rows[i].x, table_rows[i].y, table_rows[i].ts,
                       table_rows[i].pol, table_rows[i].typed, typed_res);
        end
        @(negedge aclk);
        s_valid = 1'b0;
        drain();

        // Phase settings: window start, window end, target, sigma, tolerance
        phase_cfg[0] = '{0, 32'hFFFFFFFF, 100, 30, 51};
        phase_cfg[1] = '{0, 32'hFFFFFFFF, 1, 1, 0};
        phase_cfg[2] = '{0, 32'hFFFFFFFF, 100000, 65535, 255};
        phase_cfg[3] = '{0, 32'hFFFFFFFF, 0, 0, 128};
        phase_cfg[4] = '{32'hFFFFFFFF, 0, 200, 50, 64};
        for (int k = 5; k < 9; k++)
            phase_cfg[k] = '{$urandom_range(0, 2000000), 32'hF0000000 + $urandom_range(0, 1000),
                             $urandom_range(20, 5000), $urandom_range(1, 2000),
                             $urandom_range(0, 255)};

        for (int ph = 0; ph < 9; ph++) begin
            for (int r = 0; r < 5; r++) reg_write(r[2:0], phase_cfg[ph][r]);
            half_period = (target_hz == 0) ? 32'd5000 : 32'd1000000 / target_hz;
            for (int k = 0; k < 12; k++) begin
                pix_x[k] = (k == 0) ? WIDTH - 1 : $urandom_range(0, WIDTH - 1);
                pix_y[k] = (k == 0) ? HEIGHT - 1 : $urandom_range(0, HEIGHT - 1);
                pix_t[k] = 32'd3000000 + ph * 32'd1000000 + $urandom_range(0, 1000);
                pix_p[k] = $urandom_range(0, 1);
            end
            if (ph == 1) holdoff_req = 1'b1;
            for (int n = 0; n < 160; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any position, any time
                    typed_res = '{0, 0, 0, 0};
                    send_event($urandom_range(0, 2047), $urandom_range(0, 1023), $urandom,
                               $urandom_range(0, 1), 0, typed_res);
                end else begin
                    // Blinking pixel near the target rate, sometimes repeating polarity
                    p = $urandom_range(0, 11);
                    jitter = half_period / 8 + 1;
                    pix_t[p] = pix_t[p] + half_period - jitter + $urandom_range(0, 2 * jitter);
                    if ($urandom_range(0, 6) != 0) pix_p[p] = ~pix_p[p];
                    send_event(pix_x[p], pix_y[p], pix_t[p], pix_p[p], 0, typed_res);
                end
            end
            @(negedge aclk);
            s_valid = 1'b0;
            drain();
        end

        $display("Sent %0d events over 10 register settings; %0d results checked, %0d with weight.",
                 events_sent, results_seen, weighted_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/fpe_pkg.sv
sv/fpe_ram.sv
sv/fpe_div.sv
sv/event_pixel_flicker_evidence.sv
verif/tb_event_pixel_flicker_evidence.sv
